>>> rtl/fcpd_pkg.sv
// fcpd_pkg: shared constants, result type and pin lookup functions for the
// framed command pin decoder. No dependencies.
package fcpd_pkg;

  localparam logic [7:0] HDR_BYTE      = 8'hC0;
  localparam logic [7:0] TRL_BYTE      = 8'hC1;
  localparam logic [7:0] MAX_LEN_RESET = 8'd200;
  localparam logic [7:0] KIND_MIN      = 8'd1;
  localparam logic [7:0] KIND_MAX      = 8'd4;
  localparam logic [7:0] CODE_MAX      = 8'd30;

  localparam logic [2:0] KIND_ATTEN_ONE = 3'd1;
  localparam logic [2:0] KIND_ATTEN_TWO = 3'd2;
  localparam logic [2:0] KIND_LINK      = 3'd3;
  localparam logic [2:0] KIND_BAND      = 3'd4;

  localparam logic [7:0] BAND_STEP = 8'd30;
  localparam logic [7:0] BAND_MID  = 8'd60;
  localparam logic [7:0] BAND_TOP  = 8'd90;

  typedef struct packed {
    logic [9:0]  atten_one_pins;
    logic [9:0]  atten_two_pins;
    logic [19:0] link_pins;
    logic        frame_done;
    logic        frame_dropped;
  } result_t;

  function automatic logic [19:0] code_mask(input logic [4:0] code);
    logic [19:0] m;
    case (code)
      5'd1,  5'd2:  m = 20'h80000;
      5'd3,  5'd4:  m = 20'h40000;
      5'd5,  5'd6:  m = 20'h20000;
      5'd7,  5'd8:  m = 20'h14000;
      5'd9,  5'd10: m = 20'h0C000;
      5'd11, 5'd12: m = 20'h02800;
      5'd13, 5'd14: m = 20'h01800;
      5'd15, 5'd16: m = 20'h00400;
      5'd17, 5'd18: m = 20'h00027;
      5'd19, 5'd20: m = 20'h00017;
      5'd21, 5'd22: m = 20'h0000F;
      5'd23, 5'd24: m = 20'h00200;
      5'd25, 5'd26: m = 20'h00100;
      5'd27, 5'd28: m = 20'h00080;
      5'd29, 5'd30: m = 20'h00040;
      default:      m = 20'h00000;
    endcase
    return m;
  endfunction

  function automatic logic [19:0] code_value(input logic [4:0] code);
    logic [19:0] v;
    case (code)
      5'd2:    v = 20'h80000;
      5'd4:    v = 20'h40000;
      5'd6:    v = 20'h20000;
      5'd8:    v = 20'h10000;
      5'd9:    v = 20'h04000;
      5'd10:   v = 20'h0C000;
      5'd12:   v = 20'h02000;
      5'd13:   v = 20'h00800;
      5'd14:   v = 20'h01800;
      5'd16:   v = 20'h00400;
      5'd17:   v = 20'h00004;
      5'd18:   v = 20'h00024;
      5'd19:   v = 20'h00002;
      5'd20:   v = 20'h00012;
      5'd21:   v = 20'h00001;
      5'd22:   v = 20'h00009;
      5'd24:   v = 20'h00200;
      5'd26:   v = 20'h00100;
      5'd28:   v = 20'h00080;
      5'd30:   v = 20'h00040;
      default: v = 20'h00000;
    endcase
    return v;
  endfunction

  // band select in bits 9:8 and 1:0, doubled step code in bits 7:2
  function automatic logic [9:0] band_pins(input logic [9:0] old, input logic [7:0] v);
    logic [9:0] res;
    logic [7:0] step;
    step = 8'd0;
    res  = old;
    if (v <= BAND_STEP) begin
      step = v;
      res  = {2'd1, step[4:0], 1'b0, 2'd1};
    end else if (v <= BAND_MID) begin
      step = v - BAND_STEP;
      res  = {2'd2, step[4:0], 1'b0, 2'd1};
    end else if (v <= BAND_TOP) begin
      step = v - BAND_MID;
      res  = {2'd2, step[4:0], 1'b0, 2'd2};
    end
    return res;
  endfunction

endpackage

>>> rtl/fcpd_parser.sv
// fcpd_parser: frame parser, payload capture and pin state for the decoder.
// Updates once per accepted byte. Depends on fcpd_pkg.
module fcpd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        max_len,
  output fcpd_pkg::result_t result
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_TYPE,
    PH_LEN,
    PH_PAYLOAD,
    PH_TRAILER
  } phase_t;

  phase_t            phase, phase_next;
  logic [2:0]        kind, kind_next;
  logic [7:0]        bytes_left, bytes_left_next;
  logic [7:0]        payload_index, payload_index_next;
  logic [3:0][7:0]   captured, captured_next;
  logic [19:0]       link_mask, link_mask_next;
  logic [19:0]       link_value, link_value_next;
  fcpd_pkg::result_t result_next;
  logic [19:0]       m;

  always_comb begin
    phase_next         = phase;
    kind_next          = kind;
    bytes_left_next    = bytes_left;
    payload_index_next = payload_index;
    captured_next      = captured;
    link_mask_next     = link_mask;
    link_value_next    = link_value;
    result_next        = result;
    result_next.frame_done    = 1'b0;
    result_next.frame_dropped = 1'b0;
    m = fcpd_pkg::code_mask(rx_byte[4:0]);

    case (phase)
      PH_HUNT: begin
        if (rx_byte == fcpd_pkg::HDR_BYTE) begin
          phase_next         = PH_TYPE;
          kind_next          = 3'd0;
          bytes_left_next    = 8'd0;
          payload_index_next = 8'd0;
          captured_next      = '0;
          link_mask_next     = '0;
          link_value_next    = '0;
        end
      end
      PH_TYPE: begin
        if (rx_byte inside {[fcpd_pkg::KIND_MIN:fcpd_pkg::KIND_MAX]}) begin
          kind_next  = rx_byte[2:0];
          phase_next = PH_LEN;
        end else begin
          result_next.frame_dropped = 1'b1;
          phase_next = PH_HUNT;
        end
      end
      PH_LEN: begin
        if (rx_byte > max_len) begin
          result_next.frame_dropped = 1'b1;
          phase_next = PH_HUNT;
        end else begin
          bytes_left_next = rx_byte;
          phase_next = (rx_byte == 8'd0) ? PH_TRAILER : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (payload_index <= 8'd2) begin
          captured_next[payload_index[1:0]] = rx_byte;
        end else if (payload_index == 8'd4) begin
          captured_next[3] = rx_byte;
        end
        if (kind == fcpd_pkg::KIND_LINK && rx_byte <= fcpd_pkg::CODE_MAX) begin
          link_mask_next  = link_mask | m;
          link_value_next = (link_value & ~m) | (fcpd_pkg::code_value(rx_byte[4:0]) & m);
        end
        payload_index_next = payload_index + 8'd1;
        bytes_left_next    = bytes_left - 8'd1;
        if (bytes_left == 8'd1) begin
          phase_next = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        if (rx_byte == fcpd_pkg::TRL_BYTE) begin
          result_next.frame_done = 1'b1;
          case (kind)
            fcpd_pkg::KIND_ATTEN_ONE: begin
              result_next.atten_one_pins =
                {captured[0][1:0], captured[1][5:0], captured[2][1:0]};
            end
            fcpd_pkg::KIND_ATTEN_TWO: begin
              result_next.atten_two_pins =
                {captured[0][1:0], captured[1][5:0], captured[2][1:0]};
            end
            fcpd_pkg::KIND_LINK: begin
              result_next.link_pins = (result.link_pins & ~link_mask) |
                                      (link_value & link_mask);
            end
            fcpd_pkg::KIND_BAND: begin
              result_next.atten_one_pins =
                fcpd_pkg::band_pins(result.atten_one_pins, captured[0]);
              result_next.atten_two_pins =
                fcpd_pkg::band_pins(result.atten_two_pins, captured[3]);
            end
            default: begin
            end
          endcase
        end else begin
          result_next.frame_dropped = 1'b1;
        end
        phase_next = PH_HUNT;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      kind          <= 3'd0;
      bytes_left    <= 8'd0;
      payload_index <= 8'd0;
      captured      <= '0;
      link_mask     <= '0;
      link_value    <= '0;
      result        <= '0;
    end else if (step) begin
      phase         <= phase_next;
      kind          <= kind_next;
      bytes_left    <= bytes_left_next;
      payload_index <= payload_index_next;
      captured      <= captured_next;
      link_mask     <= link_mask_next;
      link_value    <= link_value_next;
      result        <= result_next;
    end
  end

endmodule

>>> rtl/framed_command_pin_decoder.sv
// framed_command_pin_decoder: top level, stream handshake, length limit
// register and output beat. Depends on fcpd_pkg and fcpd_parser.
//
//   channel   dir   width  contents
//   s_axis    in    8      rx_byte
//   m_axis    out   40+2   pin levels after the byte, done/dropped flags
//   cfg       in    8      max_payload_len
//
// One byte per cycle while s_axis_tready is high; each byte gives one result
// beat in the cycle after it is taken. The parser state and the result register update together.
// s_axis_tready is low only while a result beat waits on m_axis_tready.
// Reset clears all pins low, hunts for a header, and sets the limit to 200.
module framed_command_pin_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [9:0] atten_one_pins, [19:10] atten_two_pins,
                                     // [39:20] link_pins
  output logic [1:0]  m_axis_tuser,  // [0] frame_done, [1] frame_dropped
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  logic              step;
  logic [7:0]        max_len;
  fcpd_pkg::result_t result;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len       <= fcpd_pkg::MAX_LEN_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_len <= cfg_wdata;
      end
      if (step) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  fcpd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (s_axis_tdata),
    .max_len (max_len),
    .result  (result)
  );

  assign m_axis_tdata = {result.link_pins, result.atten_two_pins, result.atten_one_pins};
  assign m_axis_tuser = {result.frame_dropped, result.frame_done};

endmodule

>>> rtl/fcpd_checker.sv
// fcpd_checker: port-level checks for framed_command_pin_decoder, attached
// by bind. Depends only on the top level's ports.
module fcpd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("done and dropped both set");

  a_no_take_while_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("byte taken while result beat stalled");

  a_pins_hold_without_done: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && $past(s_axis_tvalid && s_axis_tready) && !m_axis_tuser[0])
      |-> (m_axis_tdata == $past(m_axis_tdata)))
    else $error("pins changed without a completed frame");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result beat changed");

endmodule

bind framed_command_pin_decoder fcpd_checker u_fcpd_checker (.*);
